/* sv/tgcb_pkg.sv */
package tgcb_pkg;

  // Height limits of the grid
  localparam int unsigned MIN_HEIGHT    = 1;
  localparam int unsigned MAX_HEIGHT    = 1023;
  localparam int unsigned EMPTY_HEIGHT  = 0;
  localparam int unsigned CELL_CAPACITY = 65536;

  // Running counts saturate at the capacity or at the counter's full scale
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CNT_LIMIT = (CELL_CAPACITY < 131071) ? CELL_CAPACITY : 131071;

  // Configuration channel
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POINT   = 3'd0,
    REG_END_POINT     = 3'd1,
    REG_START_HEIGHT  = 3'd2,
    REG_END_HEIGHT    = 3'd3,
    REG_HALF_WIDTH    = 3'd4,
    REG_FALLOFF_WIDTH = 3'd5,
    REG_CROSS_SLOPE   = 3'd6
  } cfg_reg_e;

  // Sequencer steps
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_TSEL, ST_TDIV, ST_TEND,
    ST_OX, ST_OZ, ST_OZ2,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_DSQRT,
    ST_CLASS, ST_WDIV, ST_WEND,
    ST_TG0, ST_TG1, ST_LSQRT,
    ST_LM, ST_PX, ST_PZ, ST_C1, ST_C2, ST_C3,
    ST_CN, ST_CDIV, ST_CEND,
    ST_RND, ST_B0, ST_B1, ST_B2,
    ST_DONE
  } state_e;

endpackage

/* sv/tgcb_cfg_if.sv */
interface tgcb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tgcb_pkg::CFG_IDX_W-1:0]   index;
  logic [tgcb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tgcb_cell_if.sv */
interface tgcb_cell_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_z;
  logic [15:0]        source_height;
  logic               first_of_job;

  modport source (output valid, output cell_x, output cell_z, output source_height,
                  output first_of_job, input ready);
  modport sink   (input valid, input cell_x, input cell_z, input source_height,
                  input first_of_job, output ready);
endinterface

/* sv/tgcb_result_if.sv */
interface tgcb_result_if;
  logic                         valid;
  logic                         ready;
  logic [15:0]                  graded_height;
  logic                         influenced;
  logic                         in_corridor;
  logic                         changed;
  logic                         target_out_of_range;
  logic [tgcb_pkg::CNT_W-1:0]   corridor_total;
  logic [tgcb_pkg::CNT_W-1:0]   falloff_total;
  logic [tgcb_pkg::CNT_W-1:0]   changed_total;
  logic                         error_seen;

  modport source (output valid, output graded_height, output influenced, output in_corridor,
                  output changed, output target_out_of_range, output corridor_total,
                  output falloff_total, output changed_total, output error_seen,
                  input ready);
  modport sink   (input valid, input graded_height, input influenced, input in_corridor,
                  input changed, input target_out_of_range, input corridor_total,
                  input falloff_total, input changed_total, input error_seen,
                  output ready);
endinterface

/* sv/terrain_grade_cell_blend_unit.sv */
// Grades one height-field cell per beat against a configured road segment. Each cell is
// worked through a small sequencer around one shared 28x28 signed multiplier and one
// shared 52-bit subtractor, which serves both a restoring divider and a square root, one
// bit per cycle. A cell in the corridor or falloff band takes longer than one outside,
// mostly in the 40-step divide of the cross-slope term and two 26-step square roots.
// The cell channel is ready only while the sequencer is idle; the result sits in an
// output register, so the next cell is taken while an earlier result still waits. The
// configuration channel is always ready and must be written while idle; nothing enforces it.
module terrain_grade_cell_blend_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  tgcb_cfg_if.sink      cfg_i,
  tgcb_cell_if.sink     cell_i,
  tgcb_result_if.source result_o
);

  localparam int unsigned SQ_W  = 52;
  localparam int unsigned SUB_W = 52;
  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << 50;
  localparam logic signed [47:0] TGT_MIN = 48'(tgcb_pkg::MIN_HEIGHT);
  localparam logic signed [47:0] TGT_MAX = 48'(tgcb_pkg::MAX_HEIGHT);
  localparam logic [16:0] W_ONE = 17'h10000;

  // Round a Q8 fraction off, half away from zero
  function automatic logic signed [47:0] rnd8(input logic signed [55:0] n);
    logic [55:0] m;
    logic [47:0] q;
    m = n[55] ? 56'(-n) : 56'(n);
    q = 48'((m + 56'd128) >> 8);
    return n[55] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [tgcb_pkg::CNT_W-1:0] bump(input logic [tgcb_pkg::CNT_W-1:0] c);
    return (c < tgcb_pkg::CNT_W'(tgcb_pkg::CNT_LIMIT)) ? c + 1'b1
                                                     : tgcb_pkg::CNT_W'(tgcb_pkg::CNT_LIMIT);
  endfunction

  // Configuration registers
  logic [31:0]        start_point_q, end_point_q;
  logic [15:0]        start_height_q, end_height_q;
  logic [7:0]         half_width_q, falloff_width_q;
  logic signed [10:0] perm_q;

  // Sequencer and datapath registers
  tgcb_pkg::state_e state_q, state_d;
  logic [5:0]          cnt_q, cnt_d;
  logic signed [55:0]  prod_q;
  logic [33:0]         len2_q, len2_d;
  logic signed [34:0]  dot_q, dot_d;
  logic [16:0]         t_q, t_d;
  logic signed [27:0]  ox8_q, ox8_d, oz8_q, oz8_d;
  logic [SQ_W-1:0]     sqv_q, sqv_d, sqr_q, sqr_d, sqbit_q, sqbit_d;
  logic [36:0]         rem_q, rem_d, divisor_q, divisor_d;
  logic [39:0]         dq_q, dq_d;
  logic                infl_q, infl_d, corr_q, corr_d, oor_q, oor_d;
  logic [15:0]         outh_q, outh_d;
  logic [16:0]         w_q, w_d;
  logic signed [47:0]  tgt8_q, tgt8_d;
  logic [35:0]         d_q, d_d;
  logic signed [27:0]  pdx_q, pdx_d, pdz_q, pdz_d;
  logic signed [44:0]  cp_q, cp_d;
  logic [15:0]         target_q, target_d;
  logic [33:0]         bacc_q, bacc_d;
  logic signed [15:0]  cell_x_q, cell_x_d, cell_z_q, cell_z_d;
  logic [15:0]         src_q, src_d;
  logic                first_q, first_d;

  // Job state and output register
  logic [tgcb_pkg::CNT_W-1:0] corr_cnt_q, corr_cnt_d, fall_cnt_q, fall_cnt_d;
  logic [tgcb_pkg::CNT_W-1:0] chg_cnt_q, chg_cnt_d;
  logic                       err_q, err_d;
  logic                       out_valid_q, out_valid_d;
  logic [15:0]                out_height_q, out_height_d;
  logic                       out_infl_q, out_infl_d, out_corr_q, out_corr_d;
  logic                       out_chg_q, out_chg_d, out_oor_q, out_oor_d;

  // Shared units
  logic signed [27:0]  mul_a, mul_b;
  logic [SUB_W-1:0]    sub_a, sub_b;
  logic [SUB_W:0]      sub_diff;
  logic                sub_ge;

  // Geometry
  logic signed [15:0]  sx, sz, ex, ez;
  logic signed [16:0]  dx, dz, rx, rz, hdiff;
  logic                dot_le0, dot_ge;
  logic [25:0]         dist8;
  logic [15:0]         hw8;
  logic [17:0]         outer8, wdiff;
  logic                infl_c, corr_c, oor_c;
  logic signed [47:0]  target_r;
  logic [44:0]         cp_mag;
  logic [61:0]         cnum;
  logic [34:0]         bsum;
  logic [18:0]         bval;
  logic                load_out;
  logic [tgcb_pkg::CNT_W-1:0] base_corr, base_fall, base_chg;
  logic                chg_c;

  assign sx = start_point_q[31:16];
  assign sz = start_point_q[15:0];
  assign ex = end_point_q[31:16];
  assign ez = end_point_q[15:0];
  assign dx = 17'(ex) - 17'(sx);
  assign dz = 17'(ez) - 17'(sz);
  assign rx = 17'(cell_x_q) - 17'(sx);
  assign rz = 17'(cell_z_q) - 17'(sz);
  assign hdiff = $signed({1'b0, end_height_q}) - $signed({1'b0, start_height_q});

  // Projection clamp tests
  assign dot_le0 = dot_q[34] || (dot_q == '0);
  assign dot_ge  = !dot_q[34] && (dot_q[33:0] >= len2_q);

  // Band classification
  assign dist8  = sqr_q[25:0];
  assign hw8    = {half_width_q, 8'b0};
  assign outer8 = 18'(hw8) + 18'({falloff_width_q, 8'b0});
  assign infl_c = 26'(outer8) >= dist8;
  assign corr_c = 26'(hw8) >= dist8;
  assign wdiff  = outer8 - dist8[17:0];

  // Target range check
  assign target_r = rnd8(56'(tgt8_q));
  assign oor_c    = (target_r < TGT_MIN) || (target_r > TGT_MAX);

  // Cross-slope numerator with rounding term
  assign cp_mag = cp_q[44] ? 45'(-cp_q) : 45'(cp_q);
  assign cnum   = {cp_mag, 17'b0} + 62'(d_q);

  // Blend sum
  assign bsum = 35'(bacc_q) + 35'(prod_q[33:0]) + 35'd32768;
  assign bval = bsum[34:16];

  // Shared subtractor
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SUB_W];

  // Output handshake
  assign load_out = (state_q == tgcb_pkg::ST_DONE) && (!out_valid_q || result_o.ready);
  assign base_corr = first_q ? '0 : corr_cnt_q;
  assign base_fall = first_q ? '0 : fall_cnt_q;
  assign base_chg  = first_q ? '0 : chg_cnt_q;
  assign chg_c     = outh_q != src_q;

  assign cfg_i.ready  = 1'b1;
  assign cell_i.ready = (state_q == tgcb_pkg::ST_IDLE);

  assign result_o.valid               = out_valid_q;
  assign result_o.graded_height       = out_height_q;
  assign result_o.influenced          = out_infl_q;
  assign result_o.in_corridor         = out_corr_q;
  assign result_o.changed             = out_chg_q;
  assign result_o.target_out_of_range = out_oor_q;
  assign result_o.corridor_total      = corr_cnt_q;
  assign result_o.falloff_total       = fall_cnt_q;
  assign result_o.changed_total       = chg_cnt_q;
  assign result_o.error_seen          = err_q;

  // Next step of the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgcb_pkg::ST_IDLE:  if (cell_i.valid) state_d = tgcb_pkg::ST_M0;
      tgcb_pkg::ST_M0:    state_d = tgcb_pkg::ST_M1;
      tgcb_pkg::ST_M1:    state_d = tgcb_pkg::ST_M2;
      tgcb_pkg::ST_M2:    state_d = tgcb_pkg::ST_M3;
      tgcb_pkg::ST_M3:    state_d = tgcb_pkg::ST_M4;
      tgcb_pkg::ST_M4:    state_d = tgcb_pkg::ST_TSEL;
      tgcb_pkg::ST_TSEL:  state_d = (dot_le0 || dot_ge) ? tgcb_pkg::ST_OX : tgcb_pkg::ST_TDIV;
      tgcb_pkg::ST_TDIV:  if (cnt_q == 6'd1) state_d = tgcb_pkg::ST_TEND;
      tgcb_pkg::ST_TEND:  state_d = tgcb_pkg::ST_OX;
      tgcb_pkg::ST_OX:    state_d = tgcb_pkg::ST_OZ;
      tgcb_pkg::ST_OZ:    state_d = tgcb_pkg::ST_OZ2;
      tgcb_pkg::ST_OZ2:   state_d = tgcb_pkg::ST_SQ0;
      tgcb_pkg::ST_SQ0:   state_d = tgcb_pkg::ST_SQ1;
      tgcb_pkg::ST_SQ1:   state_d = tgcb_pkg::ST_SQ2;
      tgcb_pkg::ST_SQ2:   state_d = tgcb_pkg::ST_DSQRT;
      tgcb_pkg::ST_DSQRT: if (cnt_q == 6'd1) state_d = tgcb_pkg::ST_CLASS;
      tgcb_pkg::ST_CLASS: begin
        if (!infl_c) state_d = tgcb_pkg::ST_DONE;
        else if (corr_c || (falloff_width_q == '0)) state_d = tgcb_pkg::ST_TG0;
        else state_d = tgcb_pkg::ST_WDIV;
      end
      tgcb_pkg::ST_WDIV:  if (cnt_q == 6'd1) state_d = tgcb_pkg::ST_WEND;
      tgcb_pkg::ST_WEND:  state_d = tgcb_pkg::ST_TG0;
      tgcb_pkg::ST_TG0:   state_d = tgcb_pkg::ST_TG1;
      tgcb_pkg::ST_TG1:   state_d = (len2_q == '0) ? tgcb_pkg::ST_RND : tgcb_pkg::ST_LSQRT;
      tgcb_pkg::ST_LSQRT: if (cnt_q == 6'd1) state_d = tgcb_pkg::ST_LM;
      tgcb_pkg::ST_LM:    state_d = tgcb_pkg::ST_PX;
      tgcb_pkg::ST_PX:    state_d = tgcb_pkg::ST_PZ;
      tgcb_pkg::ST_PZ:    state_d = tgcb_pkg::ST_C1;
      tgcb_pkg::ST_C1:    state_d = tgcb_pkg::ST_C2;
      tgcb_pkg::ST_C2:    state_d = tgcb_pkg::ST_C3;
      tgcb_pkg::ST_C3:    state_d = tgcb_pkg::ST_CN;
      tgcb_pkg::ST_CN:    state_d = tgcb_pkg::ST_CDIV;
      tgcb_pkg::ST_CDIV:  if (cnt_q == 6'd1) state_d = tgcb_pkg::ST_CEND;
      tgcb_pkg::ST_CEND:  state_d = tgcb_pkg::ST_RND;
      tgcb_pkg::ST_RND:   state_d = oor_c ? tgcb_pkg::ST_DONE : tgcb_pkg::ST_B0;
      tgcb_pkg::ST_B0:    state_d = tgcb_pkg::ST_B1;
      tgcb_pkg::ST_B1:    state_d = tgcb_pkg::ST_B2;
      tgcb_pkg::ST_B2:    state_d = tgcb_pkg::ST_DONE;
      tgcb_pkg::ST_DONE:  if (load_out) state_d = tgcb_pkg::ST_IDLE;
      default:            state_d = tgcb_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls for each step
  always_comb begin
    cnt_d    = cnt_q;
    len2_d   = len2_q;
    dot_d    = dot_q;
    t_d      = t_q;
    ox8_d    = ox8_q;
    oz8_d    = oz8_q;
    sqv_d    = sqv_q;
    sqr_d    = sqr_q;
    sqbit_d  = sqbit_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    divisor_d = divisor_q;
    infl_d   = infl_q;
    corr_d   = corr_q;
    oor_d    = oor_q;
    outh_d   = outh_q;
    w_d      = w_q;
    tgt8_d   = tgt8_q;
    d_d      = d_q;
    pdx_d    = pdx_q;
    pdz_d    = pdz_q;
    cp_d     = cp_q;
    target_d = target_q;
    bacc_d   = bacc_q;
    cell_x_d = cell_x_q;
    cell_z_d = cell_z_q;
    src_d    = src_q;
    first_d  = first_q;
    mul_a    = '0;
    mul_b    = '0;
    sub_a    = '0;
    sub_b    = '0;
    corr_cnt_d   = corr_cnt_q;
    fall_cnt_d   = fall_cnt_q;
    chg_cnt_d    = chg_cnt_q;
    err_d        = err_q;
    out_height_d = out_height_q;
    out_infl_d   = out_infl_q;
    out_corr_d   = out_corr_q;
    out_chg_d    = out_chg_q;
    out_oor_d    = out_oor_q;
    out_valid_d  = (out_valid_q && result_o.ready) ? 1'b0 : out_valid_q;

    unique case (state_q) inside
      tgcb_pkg::ST_IDLE: begin
        // take the cell beat
        if (cell_i.valid) begin
          cell_x_d = cell_i.cell_x;
          cell_z_d = cell_i.cell_z;
          src_d    = cell_i.source_height;
          first_d  = cell_i.first_of_job;
        end
      end
      tgcb_pkg::ST_M0: begin
        mul_a = 28'(dx);
        mul_b = 28'(dx);
      end
      tgcb_pkg::ST_M1: begin
        len2_d = prod_q[33:0];
        mul_a  = 28'(dz);
        mul_b  = 28'(dz);
      end
      tgcb_pkg::ST_M2: begin
        len2_d = len2_q + prod_q[33:0];
        mul_a  = 28'(rx);
        mul_b  = 28'(dx);
      end
      tgcb_pkg::ST_M3: begin
        dot_d = prod_q[34:0];
        mul_a = 28'(rz);
        mul_b = 28'(dz);
      end
      tgcb_pkg::ST_M4: begin
        dot_d = dot_q + prod_q[34:0];
      end
      tgcb_pkg::ST_TSEL: begin
        // clamp t at the segment ends, else divide dot by len2
        if (dot_le0) begin
          t_d = '0;
        end else if (dot_ge) begin
          t_d = W_ONE;
        end else begin
          rem_d     = 37'(dot_q[33:0]);
          dq_d      = '0;
          divisor_d = 37'(len2_q);
          cnt_d     = 6'd16;
        end
      end
      tgcb_pkg::ST_TDIV, tgcb_pkg::ST_WDIV, tgcb_pkg::ST_CDIV: begin
        // one restoring divide step
        sub_a     = SUB_W'({rem_q, dq_q[39]});
        sub_b     = SUB_W'(divisor_q);
        rem_d     = sub_ge ? sub_diff[36:0] : {rem_q[35:0], dq_q[39]};
        dq_d      = {dq_q[38:0], sub_ge};
        cnt_d     = cnt_q - 6'd1;
      end
      tgcb_pkg::ST_TEND: begin
        t_d = {1'b0, dq_q[15:0]};
      end
      tgcb_pkg::ST_OX: begin
        mul_a = $signed({11'b0, t_q});
        mul_b = 28'(dx);
      end
      tgcb_pkg::ST_OZ: begin
        ox8_d = 28'(rnd8($signed({{23{rx[16]}}, rx, 16'b0}) - prod_q));
        mul_a = $signed({11'b0, t_q});
        mul_b = 28'(dz);
      end
      tgcb_pkg::ST_OZ2: begin
        oz8_d = 28'(rnd8($signed({{23{rz[16]}}, rz, 16'b0}) - prod_q));
      end
      tgcb_pkg::ST_SQ0: begin
        mul_a = ox8_q;
        mul_b = ox8_q;
      end
      tgcb_pkg::ST_SQ1: begin
        sqv_d = prod_q[SQ_W-1:0];
        mul_a = oz8_q;
        mul_b = oz8_q;
      end
      tgcb_pkg::ST_SQ2: begin
        sqv_d   = sqv_q + prod_q[SQ_W-1:0];
        sqr_d   = '0;
        sqbit_d = SQ_TOP;
        cnt_d   = 6'd26;
      end
      tgcb_pkg::ST_DSQRT, tgcb_pkg::ST_LSQRT: begin
        // one square-root digit
        sub_a   = sqv_q;
        sub_b   = sqr_q | sqbit_q;
        if (sub_ge) sqv_d = sub_diff[SQ_W-1:0];
        sqr_d   = sub_ge ? ((sqr_q >> 1) | sqbit_q) : (sqr_q >> 1);
        sqbit_d = sqbit_q >> 2;
        cnt_d   = cnt_q - 6'd1;
      end
      tgcb_pkg::ST_CLASS: begin
        infl_d = infl_c;
        corr_d = corr_c;
        oor_d  = 1'b0;
        outh_d = src_q;
        w_d    = W_ONE;
        // fade band: weight by the remaining distance
        if (infl_c && !corr_c && (falloff_width_q != '0)) begin
          rem_d     = 37'(wdiff[17:8]);
          dq_d      = {wdiff[7:0], 32'b0};
          divisor_d = 37'(falloff_width_q);
          cnt_d     = 6'd16;
        end
      end
      tgcb_pkg::ST_WEND: begin
        w_d = {1'b0, dq_q[15:0]};
      end
      tgcb_pkg::ST_TG0: begin
        mul_a = $signed({11'b0, t_q});
        mul_b = 28'(hdiff);
      end
      tgcb_pkg::ST_TG1: begin
        tgt8_d  = $signed({24'b0, start_height_q, 8'b0}) + rnd8(prod_q);
        sqv_d   = {2'b0, len2_q, 16'b0};
        sqr_d   = '0;
        sqbit_d = SQ_TOP;
        cnt_d   = 6'd26;
      end
      tgcb_pkg::ST_LM: begin
        mul_a = $signed({3'b0, sqr_q[24:0]});
        mul_b = 28'sd1000;
      end
      tgcb_pkg::ST_PX: begin
        d_d   = prod_q[35:0];
        mul_a = 28'(perm_q);
        mul_b = 28'(dx);
      end
      tgcb_pkg::ST_PZ: begin
        pdx_d = prod_q[27:0];
        mul_a = 28'(perm_q);
        mul_b = 28'(dz);
      end
      tgcb_pkg::ST_C1: begin
        pdz_d = prod_q[27:0];
        mul_a = pdx_q;
        mul_b = 28'(rz);
      end
      tgcb_pkg::ST_C2: begin
        cp_d  = prod_q[44:0];
        mul_a = pdz_q;
        mul_b = 28'(rx);
      end
      tgcb_pkg::ST_C3: begin
        cp_d = cp_q - prod_q[44:0];
      end
      tgcb_pkg::ST_CN: begin
        // rounded divide by 1000 * len8, quotient below 2^40
        rem_d     = 37'(cnum[61:40]);
        dq_d      = cnum[39:0];
        divisor_d = {d_q, 1'b0};
        cnt_d     = 6'd40;
      end
      tgcb_pkg::ST_CEND: begin
        tgt8_d = cp_q[44] ? tgt8_q - $signed({8'b0, dq_q}) : tgt8_q + $signed({8'b0, dq_q});
      end
      tgcb_pkg::ST_RND: begin
        target_d = target_r[15:0];
        oor_d    = oor_c;
      end
      tgcb_pkg::ST_B0: begin
        mul_a = $signed({12'b0, src_q});
        mul_b = $signed({11'b0, W_ONE - w_q});
      end
      tgcb_pkg::ST_B1: begin
        bacc_d = prod_q[33:0];
        mul_a  = $signed({12'b0, target_q});
        mul_b  = $signed({11'b0, w_q});
      end
      tgcb_pkg::ST_B2: begin
        // clamp the blend into the height range
        if (bval > 19'(tgcb_pkg::MAX_HEIGHT)) outh_d = 16'(tgcb_pkg::MAX_HEIGHT);
        else if (bval < 19'(tgcb_pkg::EMPTY_HEIGHT)) outh_d = 16'(tgcb_pkg::EMPTY_HEIGHT);
        else outh_d = bval[15:0];
      end
      tgcb_pkg::ST_DONE: begin
        // hand over the result and advance the job counts
        if (load_out) begin
          corr_cnt_d   = (infl_q && corr_q) ? bump(base_corr) : base_corr;
          fall_cnt_d   = (infl_q && !corr_q) ? bump(base_fall) : base_fall;
          chg_cnt_d    = chg_c ? bump(base_chg) : base_chg;
          err_d        = (err_q && !first_q) || oor_q;
          out_height_d = outh_q;
          out_infl_d   = infl_q;
          out_corr_d   = infl_q && corr_q;
          out_chg_d    = chg_c;
          out_oor_d    = oor_q;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_point_q   <= '0;
      end_point_q     <= 32'h0001_0000;
      start_height_q  <= '0;
      end_height_q    <= '0;
      half_width_q    <= '0;
      falloff_width_q <= '0;
      perm_q          <= '0;
    end else if (cfg_i.valid) begin
      unique case (tgcb_pkg::cfg_reg_e'(cfg_i.index))
        tgcb_pkg::REG_START_POINT:   start_point_q   <= cfg_i.data;
        tgcb_pkg::REG_END_POINT:     end_point_q     <= cfg_i.data;
        tgcb_pkg::REG_START_HEIGHT:  start_height_q  <= cfg_i.data[15:0];
        tgcb_pkg::REG_END_HEIGHT:    end_height_q    <= cfg_i.data[15:0];
        tgcb_pkg::REG_HALF_WIDTH:    half_width_q    <= cfg_i.data[7:0];
        tgcb_pkg::REG_FALLOFF_WIDTH: falloff_width_q <= cfg_i.data[7:0];
        tgcb_pkg::REG_CROSS_SLOPE:   perm_q          <= cfg_i.data[10:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgcb_pkg::ST_IDLE;
      cnt_q       <= '0;
      corr_cnt_q  <= '0;
      fall_cnt_q  <= '0;
      chg_cnt_q   <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      corr_cnt_q  <= corr_cnt_d;
      fall_cnt_q  <= fall_cnt_d;
      chg_cnt_q   <= chg_cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q       <= mul_a * mul_b;
    len2_q       <= len2_d;
    dot_q        <= dot_d;
    t_q          <= t_d;
    ox8_q        <= ox8_d;
    oz8_q        <= oz8_d;
    sqv_q        <= sqv_d;
    sqr_q        <= sqr_d;
    sqbit_q      <= sqbit_d;
    rem_q        <= rem_d;
    dq_q         <= dq_d;
    divisor_q    <= divisor_d;
    infl_q       <= infl_d;
    corr_q       <= corr_d;
    oor_q        <= oor_d;
    outh_q       <= outh_d;
    w_q          <= w_d;
    tgt8_q       <= tgt8_d;
    d_q          <= d_d;
    pdx_q        <= pdx_d;
    pdz_q        <= pdz_d;
    cp_q         <= cp_d;
    target_q     <= target_d;
    bacc_q       <= bacc_d;
    cell_x_q     <= cell_x_d;
    cell_z_q     <= cell_z_d;
    src_q        <= src_d;
    first_q      <= first_d;
    out_height_q <= out_height_d;
    out_infl_q   <= out_infl_d;
    out_corr_q   <= out_corr_d;
    out_chg_q    <= out_chg_d;
    out_oor_q    <= out_oor_d;
  end

endmodule

/* dv/tb_terrain_grade_cell_blend_unit.sv */
module tb_terrain_grade_cell_blend_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tgcb_pkg::*;

  typedef struct packed {
    logic [15:0]      height;
    logic             influenced;
    logic             in_corridor;
    logic             changed;
    logic             out_of_range;
    logic [CNT_W-1:0] corridor_total;
    logic [CNT_W-1:0] falloff_total;
    logic [CNT_W-1:0] changed_total;
    logic             error_seen;
  } grade_t;

  // Grading predictor with its own copy of the registers and the job counts
  class grade_board;
    logic [31:0]      seg_a, seg_b;
    logic [15:0]      height_a, height_b;
    logic [7:0]       corridor_hw, fade_w;
    logic [10:0]      slope_pm;
    logic [CNT_W-1:0] n_corr, n_fade, n_chg;
    logic             err_sticky;
    grade_t           pending[$];
    int               errors;

    function new();
      seg_a = '0; seg_b = 32'h0001_0000; height_a = '0; height_b = '0;
      corridor_hw = '0; fade_w = '0; slope_pm = '0;
      n_corr = '0; n_fade = '0; n_chg = '0; err_sticky = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] d);
      case (idx)
        REG_START_POINT:   seg_a = d;
        REG_END_POINT:     seg_b = d;
        REG_START_HEIGHT:  height_a = d[15:0];
        REG_END_HEIGHT:    height_b = d[15:0];
        REG_HALF_WIDTH:    corridor_hw = d[7:0];
        REG_FALLOFF_WIDTH: fade_w = d[7:0];
        REG_CROSS_SLOPE:   slope_pm = d[10:0];
        default: ;
      endcase
    endfunction

    static function longint round_div(longint n, longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (m * 2 + d) / (d * 2);
      return (n < 0) ? -q : q;
    endfunction

    static function longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    static function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c < CNT_LIMIT) ? c + 1'b1 : CNT_LIMIT[CNT_W-1:0];
    endfunction

    // Work out the graded cell and queue it
    function void note_cell(logic [15:0] x, logic [15:0] z, logic [15:0] h, logic first);
      longint sx, sz, ex, ez, dx, dz, rx, rz, len2, dot, t, ox8, oz8, dist8;
      longint hw8, outer8, w, tgt8, tgt, outh, src, perm, len8, crs, b;
      bit infl, corr, oor;
      grade_t g;
      sx = longint'($signed(seg_a[31:16])); sz = longint'($signed(seg_a[15:0]));
      ex = longint'($signed(seg_b[31:16])); ez = longint'($signed(seg_b[15:0]));
      perm = longint'($signed(slope_pm));
      src = longint'(h);
      dx = ex - sx; dz = ez - sz;
      rx = longint'($signed(x)) - sx; rz = longint'($signed(z)) - sz;
      len2 = dx * dx + dz * dz;
      dot = rx * dx + rz * dz;
      oor = 1'b0;
      if (first) begin
        n_corr = '0; n_fade = '0; n_chg = '0; err_sticky = 1'b0;
      end
      if (len2 == 0 || dot <= 0) t = 0;
      else if (dot >= len2) t = 65536;
      else t = (dot * 65536) / len2;
      ox8 = round_div(rx * 65536 - t * dx, 256);
      oz8 = round_div(rz * 65536 - t * dz, 256);
      dist8 = int_sqrt(longint'(ox8 * ox8 + oz8 * oz8));
      hw8 = longint'(corridor_hw) * 256;
      outer8 = hw8 + longint'(fade_w) * 256;
      infl = dist8 <= outer8;
      corr = dist8 <= hw8;
      outh = src;
      if (infl) begin
        if (corr) n_corr = bump(n_corr);
        else n_fade = bump(n_fade);
        if (corr || fade_w == 0) w = 65536;
        else w = ((outer8 - dist8) * 256) / longint'(fade_w);
        tgt8 = longint'(height_a) * 256 +
               round_div(t * (longint'(height_b) - longint'(height_a)), 256);
        if (len2 != 0) begin
          len8 = int_sqrt(longint'(len2 * 65536));
          crs = dx * rz - dz * rx;
          tgt8 = tgt8 + round_div(crs * perm * 65536, 1000 * len8);
        end
        tgt = round_div(tgt8, 256);
        if (tgt < MIN_HEIGHT || tgt > MAX_HEIGHT) begin
          oor = 1'b1;
          err_sticky = 1'b1;
        end else begin
          b = (src * (65536 - w) + tgt * w + 32768) >>> 16;
          if (b > MAX_HEIGHT) b = MAX_HEIGHT;
          else if (b < EMPTY_HEIGHT) b = EMPTY_HEIGHT;
          outh = b;
        end
      end
      g.changed = outh != src;
      if (g.changed) n_chg = bump(n_chg);
      g.height = outh[15:0];
      g.influenced = infl;
      g.in_corridor = infl && corr;
      g.out_of_range = oor;
      g.corridor_total = n_corr;
      g.falloff_total = n_fade;
      g.changed_total = n_chg;
      g.error_seen = err_sticky;
      pending.push_back(g);
    endfunction

    // Compare one result beat with the oldest expected cell
    function void check(grade_t got);
      grade_t exp_g;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      exp_g = pending.pop_front();
      if (got !== exp_g) begin
        errors++;
        if (errors <= 10) $display("grade mismatch\n  exp %p\n  got %p", exp_g, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          calm = 1'b0;
  longint      cycles = 0;
  grade_board  board = new();

  tgcb_cfg_if    cfg_if();
  tgcb_cell_if   cell_if();
  tgcb_result_if res_if();

  terrain_grade_cell_blend_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .cell_i   (cell_if),
    .result_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    cfg_if.valid = 1'b0; cfg_if.index = REG_START_POINT; cfg_if.data = '0;
    cell_if.valid = 1'b0; cell_if.cell_x = '0; cell_if.cell_z = '0;
    cell_if.source_height = '0; cell_if.first_of_job = 1'b0;
    res_if.ready = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      board.check({res_if.graded_height, res_if.influenced, res_if.in_corridor,
                   res_if.changed, res_if.target_out_of_range, res_if.corridor_total,
                   res_if.falloff_total, res_if.changed_total, res_if.error_seen});
  end

  // Stall the result side in random bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) != 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.write_reg(idx, d);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_cell(logic [15:0] x, logic [15:0] z, logic [15:0] h, logic first);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cell_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    cell_if.valid         <= 1'b1;
    cell_if.cell_x        <= x;
    cell_if.cell_z        <= z;
    cell_if.source_height <= h;
    cell_if.first_of_job  <= first;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    board.note_cell(x, z, h, first);
  endtask

  // Drain all results, then let the sequencer settle
  task automatic drain();
    cell_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_road(logic [31:0] a, logic [31:0] b, logic [15:0] ha,
                          logic [15:0] hb, logic [7:0] hw, logic [7:0] fw,
                          logic [10:0] pm);
    write_reg(REG_START_POINT, a);
    write_reg(REG_END_POINT, b);
    write_reg(REG_START_HEIGHT, {16'h0, ha});
    write_reg(REG_END_HEIGHT, {16'h0, hb});
    write_reg(REG_HALF_WIDTH, {24'h0, hw});
    write_reg(REG_FALLOFF_WIDTH, {24'h0, fw});
    write_reg(REG_CROSS_SLOPE, {21'h0, pm});
  endtask

  // Pick a cell near the configured road, or anywhere now and then
  task automatic random_cell();
    int sx, sz, ex, ez, k, reach;
    logic [15:0] x, z, h;
    sx = $signed(board.seg_a[31:16]); sz = $signed(board.seg_a[15:0]);
    ex = $signed(board.seg_b[31:16]); ez = $signed(board.seg_b[15:0]);
    reach = board.corridor_hw + board.fade_w + 4;
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom; z = $urandom;
    end else begin
      k = $urandom_range(0, 120) - 10;
      x = 16'(sx + ((ex - sx) * k) / 100 + $urandom_range(0, 2 * reach) - reach);
      z = 16'(sz + ((ez - sz) * k) / 100 + $urandom_range(0, 2 * reach) - reach);
    end
    h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1100));
    send_cell(x, z, h, $urandom_range(0, 24) == 0);
  endtask

  initial begin
    int          sx, sz, ex, ez;
    logic [15:0] ha, hb;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default road: zero targets, so in-band cells fall out of range
    send_cell(16'd0, 16'd0, 16'd5, 1'b1);
    send_cell(16'd3, 16'd0, 16'd7, 1'b0);
    drain();

    // Directed road along x with a cross slope
    set_road(32'h0000_0000, 32'h0064_0000, 16'd10, 16'd500, 8'd3, 8'd4, 11'd500);
    send_cell(16'd50, 16'd0, 16'd0, 1'b1);
    send_cell(16'd50, 16'd2, 16'd65535, 1'b0);
    send_cell(16'd50, -16'sd5, 16'd200, 1'b0);
    send_cell(16'd50, 16'd7, 16'd200, 1'b0);
    send_cell(16'd50, 16'd8, 16'd200, 1'b0);
    send_cell(-16'sd2, 16'd1, 16'd100, 1'b0);
    send_cell(16'd103, 16'd0, 16'd100, 1'b0);
    send_cell(16'h8000, 16'h7fff, 16'd100, 1'b0);
    send_cell(16'h7fff, 16'h8000, 16'd100, 1'b0);
    send_cell(16'd100, 16'd0, 16'd500, 1'b0);
    drain();

    // Widest band, extreme corners and slope, hard edge and degenerate road
    set_road(32'h8000_8000, 32'h7fff_7fff, 16'd65535, 16'd0, 8'd255, 8'd255, 11'h3ff);
    send_cell(16'h0000, 16'h0000, 16'd300, 1'b1);
    send_cell(16'h8000, 16'h8000, 16'd300, 1'b0);
    send_cell(16'h0100, 16'hff00, 16'd300, 1'b0);
    drain();
    set_road(32'h0010_0010, 32'h0010_0010, 16'd400, 16'd900, 8'd2, 8'd0, 11'h400);
    send_cell(16'h0010, 16'h0011, 16'd20, 1'b1);
    send_cell(16'h0012, 16'h0010, 16'd20, 1'b0);
    send_cell(16'h0013, 16'h0010, 16'd20, 1'b0);
    drain();

    // Random roads with cells scattered around them
    for (int ph = 0; ph < 8; ph++) begin
      sx = $urandom_range(0, 4000) - 2000; sz = $urandom_range(0, 4000) - 2000;
      ex = sx + $urandom_range(0, 600) - 300; ez = sz + $urandom_range(0, 600) - 300;
      if (ph == 5) begin
        ex = sx; ez = sz;
      end
      ha = $urandom_range(1, 1023); hb = $urandom_range(1, 1023);
      set_road({16'(sx), 16'(sz)}, {16'(ex), 16'(ez)}, ha, hb,
               (ph == 2) ? 8'd0 : 8'($urandom_range(0, 30)),
               (ph == 3) ? 8'd0 : 8'($urandom_range(0, 40)),
               ($urandom_range(0, 3) == 0) ? 11'($urandom) :
                                             11'($urandom_range(0, 400) - 200));
      if (ph == 7) calm = 1'b1;
      for (int i = 0; i < 72; i++) random_cell();
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/tgcb_pkg.sv
sv/tgcb_cfg_if.sv
sv/tgcb_cell_if.sv
sv/tgcb_result_if.sv
sv/terrain_grade_cell_blend_unit.sv
dv/tb_terrain_grade_cell_blend_unit.sv
